### sv/lsh_pkg.sv
package lsh_pkg;

    // histogram geometry
    localparam int NUM_BINS_DEF = 256;
    localparam int BIN_WIDTH_US = 100;
    localparam int FULL_PERCENT = 100;

    // configuration reset value
    localparam logic [7:0] TAIL_RESET = 8'd167;

    // floor(x / 100) for any 32-bit x is (x * magic) >> 37
    localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
    localparam int          DIV100_SHIFT = 37;

endpackage

### sv/lsh_bin_mem.sv
module lsh_bin_mem #(
    parameter int NUM_BINS = lsh_pkg::NUM_BINS_DEF,
    parameter int BIN_W    = $clog2(NUM_BINS)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [BIN_W-1:0] i_waddr,
    input  logic [31:0]      i_wdata,
    input  logic [BIN_W-1:0] i_raddr,
    output logic [31:0]      o_rdata
);

    logic [31:0] r_mem [NUM_BINS];
    logic [31:0] r_rdata;

    // one write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/lsh_bin_index.sv
module lsh_bin_index #(
    parameter int NUM_BINS = lsh_pkg::NUM_BINS_DEF,
    parameter int BIN_W    = $clog2(NUM_BINS)
) (
    input  logic             i_clk,
    input  logic [31:0]      i_us,
    output logic [BIN_W-1:0] o_bin
);

    localparam int Q_W = 64 - lsh_pkg::DIV100_SHIFT;

    logic [63:0]    r_prod;
    logic [Q_W-1:0] quot;

    // reciprocal multiply, registered
    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, i_us} * {32'd0, lsh_pkg::DIV100_MAGIC};
    end

    // quotient by 100, saturated at the last bin
    assign quot  = r_prod[63:lsh_pkg::DIV100_SHIFT];
    assign o_bin = (quot >= Q_W'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1) : quot[BIN_W-1:0];

endmodule

### sv/latency_stats_histogram.sv
// Latency statistics with a histogram of NUM_BINS bins of 100 us each (the last bin
// also takes everything beyond). A record transaction updates count, 64-bit total,
// minimum, maximum and one bin through a reciprocal multiply, a bin read and a bin
// write. A query transaction walks the bin memory twice through its single read
// port, once to sum the bins and the tail and once to find the percentile bin.
// Every transaction returns exactly one result, held in an output register until
// taken; the input is accepted only between transactions. After reset a clearing
// pass over every bin zeroes the bin memory before the first transaction is
// accepted; configuration writes are taken at any time.
module latency_stats_histogram #(
    parameter int NUM_BINS = lsh_pkg::NUM_BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [31:0] i_sample_us,
    input  logic [6:0]  i_percent,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_min_us,
    output logic [31:0] o_max_us,
    output logic [63:0] o_total_us,
    output logic [31:0] o_sample_count,
    output logic        o_empty_res,
    output logic [7:0]  o_percentile_bin,
    output logic [31:0] o_tail_count
);

    localparam int BIN_W = $clog2(NUM_BINS);
    localparam int SUM_W = 32 + BIN_W;
    localparam int THR_W = SUM_W + 7;
    localparam int CMP_W = (BIN_W > 8) ? BIN_W : 8;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_REC_MUL   = 4'd2;
    localparam logic [3:0] S_REC_RD    = 4'd3;
    localparam logic [3:0] S_REC_WR    = 4'd4;
    localparam logic [3:0] S_SUM       = 4'd5;
    localparam logic [3:0] S_SUM_DRAIN = 4'd6;
    localparam logic [3:0] S_THR       = 4'd7;
    localparam logic [3:0] S_WALK      = 4'd8;
    localparam logic [3:0] S_WALK_D1   = 4'd9;
    localparam logic [3:0] S_WALK_D2   = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;

    logic [3:0]       r_state, n_state;
    logic [BIN_W-1:0] r_addr, n_addr;
    logic [7:0]       r_tail_start;

    logic             r_action;
    logic [31:0]      r_us;
    logic [6:0]       r_pct;

    logic [31:0]      r_min, r_max, r_count;
    logic [63:0]      r_total;

    logic             r_rd_vld;
    logic [BIN_W-1:0] r_rd_idx;
    logic [SUM_W-1:0] r_acc;
    logic             r_acc_vld;
    logic [BIN_W-1:0] r_acc_idx;
    logic [31:0]      r_tail;
    logic [THR_W-1:0] r_thr;
    logic             r_found;
    logic [BIN_W-1:0] r_pbin;

    logic             r_out_valid;
    logic [31:0]      r_o_min, r_o_max, r_o_count, r_o_tail;
    logic [63:0]      r_o_total;
    logic             r_o_empty;
    logic [7:0]       r_o_pbin;

    logic             in_fire;
    logic             out_load;
    logic [BIN_W-1:0] rec_bin;
    logic [31:0]      rd_data;
    logic             mem_we;
    logic [BIN_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic [BIN_W-1:0] mem_raddr;
    logic             pass_sum, pass_walk;
    logic [THR_W-1:0] run_scaled;
    logic             hit;
    logic [CMP_W-1:0] pbin_ext;

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // bin index of the latched sample
    lsh_bin_index #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W)
    ) u_bin_index (
        .i_clk (i_clk),
        .i_us  (r_us),
        .o_bin (rec_bin)
    );

    // bin count storage
    lsh_bin_mem #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W)
    ) u_bin_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // memory port steering: clearing pass, bin increment, or walk
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = 32'd0;
        mem_raddr = r_addr;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == S_REC_RD) begin
            mem_raddr = rec_bin;
        end else if (r_state == S_REC_WR) begin
            mem_we    = 1'b1;
            mem_waddr = rec_bin;
            mem_wdata = rd_data + 32'd1;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + BIN_W'(1);
                if (r_addr == LAST_BIN) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_addr = '0;
                if (in_fire) begin
                    n_state = i_action ? S_SUM : S_REC_MUL;
                end
            end
            S_REC_MUL:   n_state = S_REC_RD;
            S_REC_RD:    n_state = S_REC_WR;
            S_REC_WR:    n_state = S_DONE;
            S_SUM: begin
                n_addr = r_addr + BIN_W'(1);
                if (r_addr == LAST_BIN) begin
                    n_state = S_SUM_DRAIN;
                end
            end
            S_SUM_DRAIN: n_state = S_THR;
            S_THR: begin
                n_addr  = '0;
                n_state = S_WALK;
            end
            S_WALK: begin
                n_addr = r_addr + BIN_W'(1);
                if (r_addr == LAST_BIN) begin
                    n_state = S_WALK_D1;
                end
            end
            S_WALK_D1:   n_state = S_WALK_D2;
            S_WALK_D2:   n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tail_start <= lsh_pkg::TAIL_RESET;
        end else if (i_cfg_we) begin
            r_tail_start <= i_cfg_data;
        end
    end

    // transaction capture, percent clamped to one hundred
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_action <= i_action;
            r_us     <= i_sample_us;
            r_pct    <= (i_percent > 7'(lsh_pkg::FULL_PERCENT)) ?
                        7'(lsh_pkg::FULL_PERCENT) : i_percent;
        end
    end

    // running statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '1;
            r_max   <= '0;
            r_count <= '0;
            r_total <= '0;
        end else if (r_state == S_REC_RD) begin
            r_count <= r_count + 32'd1;
            r_total <= r_total + {32'd0, r_us};
            if (r_us > r_max) begin
                r_max <= r_us;
            end
            if (r_us < r_min) begin
                r_min <= r_us;
            end
        end
    end

    // walk data pipeline and the shared accumulator
    assign pass_sum  = (r_state == S_SUM) || (r_state == S_SUM_DRAIN);
    assign pass_walk = (r_state == S_WALK) || (r_state == S_WALK_D1) ||
                       (r_state == S_WALK_D2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld  <= 1'b0;
            r_acc_vld <= 1'b0;
        end else begin
            r_rd_vld  <= (r_state == S_SUM) || (r_state == S_WALK);
            r_acc_vld <= r_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= r_addr;
        r_acc_idx <= r_rd_idx;
        if (r_state == S_IDLE || r_state == S_THR) begin
            r_acc <= '0;
        end else if (r_rd_vld) begin
            r_acc <= r_acc + SUM_W'(rd_data);
        end
    end

    // tail count over bins at or above the configured start
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_tail <= '0;
        end else if (pass_sum && r_rd_vld &&
                     (CMP_W'(r_rd_idx) >= CMP_W'(r_tail_start))) begin
            r_tail <= r_tail + rd_data;
        end
    end

    // threshold scaled by 100: hit when 100*(run+1) > sum*percent
    always_ff @(posedge i_clk) begin
        if (r_state == S_THR) begin
            r_thr <= THR_W'(r_acc) * THR_W'(r_pct);
        end
    end

    assign run_scaled = (THR_W'(r_acc) + THR_W'(1)) * THR_W'(lsh_pkg::FULL_PERCENT);
    assign hit        = pass_walk && r_acc_vld && !r_found && (run_scaled > r_thr);

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_found <= 1'b0;
            r_pbin  <= LAST_BIN;
        end else if (hit) begin
            r_found <= 1'b1;
            r_pbin  <= r_acc_idx;
        end
    end

    // result register
    assign pbin_ext = CMP_W'(r_pbin);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_min   <= r_min;
            r_o_max   <= r_max;
            r_o_total <= r_total;
            r_o_count <= r_count;
            r_o_empty <= (r_count == 32'd0);
            r_o_pbin  <= r_action ? pbin_ext[7:0] : 8'd0;
            r_o_tail  <= r_action ? r_tail : 32'd0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_min_us         = r_o_min;
    assign o_max_us         = r_o_max;
    assign o_total_us       = r_o_total;
    assign o_sample_count   = r_o_count;
    assign o_empty_res      = r_o_empty;
    assign o_percentile_bin = r_o_pbin;
    assign o_tail_count     = r_o_tail;

endmodule
